// File: sv/exif_block_locator_core_macros.svh
// assertion macros for the exif block locator
// used by exif_block_locator_core only
`ifndef EXIF_BLOCK_LOCATOR_CORE_MACROS_SVH
`define EXIF_BLOCK_LOCATOR_CORE_MACROS_SVH
// plain implication check with reset disable
`define EBL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check with reset disable
`define EBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/exif_pkg.sv
// shared types and constants for the exif block locator
// no dependencies
`default_nettype none
package exif_pkg;

  typedef enum logic [3:0] {
    PH_SIG, PH_JM0, PH_JM1, PH_JLEN, PH_JPEEK, PH_SKIP, PH_HDR,
    PH_WPEEK, PH_BLOCK, PH_TIFF, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {C_JPEG, C_PNG, C_WEBP} cont_t;

  typedef enum logic [1:0] {
    CFG_FILE_LEN = 2'd0, CFG_META_LIM = 2'd1, CFG_REC_LIM = 2'd2, CFG_TIFF_LIM = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] OC_OK      = 2'd0;
  localparam logic [1:0] OC_DAMAGED = 2'd1;
  localparam logic [1:0] OC_LIMIT   = 2'd2;

  localparam int CFG_DATA_W = 40;
  localparam int QUEUE_SLOTS = 15;

  // result record carried through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       fin;
    logic [1:0] oc;
    logic       kept;
  } res_t;

  // burst produced by one input byte
  typedef struct packed {
    logic [3:0]        cnt;
    logic [14:0][7:0]  bytes;
    logic              fin;
    logic [1:0]        oc;
    logic              kept;
  } burst_t;

  function automatic logic [7:0] exif_hdr_byte(input logic [2:0] i);
    case (i)
      3'd0: exif_hdr_byte = 8'h45;
      3'd1: exif_hdr_byte = 8'h78;
      3'd2: exif_hdr_byte = 8'h69;
      3'd3: exif_hdr_byte = 8'h66;
      default: exif_hdr_byte = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: sv/exif_stream_if.sv
// valid/ready stream interface
// generic payload type parameter
`default_nettype none
interface exif_stream_if #(parameter type T = logic [8:0]) (input wire logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/exif_front.sv
// front: parses the byte stream and builds a burst of results per byte
// depends on exif_pkg
`default_nettype none
module exif_front import exif_pkg::*; #(
  parameter int OFFSET_BITS = 40,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  b,
  input  wire logic        eof,
  input  wire logic [39:0] file_length,
  input  wire logic [31:0] meta_lim,
  input  wire logic [15:0] rec_lim,
  input  wire logic [39:0] tiff_lim,
  output burst_t           burst
);

  localparam logic [32:0] LEN_MAX = 33'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t phase_r, phase_nxt;
  cont_t cont_r, cont_nxt;
  logic [11:0][7:0] sig_r, sig_nxt;
  logic [2:0][7:0] hdr_r, hdr_nxt;   // jpeg marker and length
  logic [7:0][7:0] chk_r, chk_nxt;   // chunk header
  logic [5:0][7:0] look_r, look_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [15:0] rec_r, rec_nxt;
  logic [1:0] oc_r, oc_nxt;
  logic fin_r, fin_nxt, skok_r, skok_nxt;
  logic [3:0] fill_r, fill_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG; cont_r <= C_JPEG; sig_r <= '0; hdr_r <= '0; chk_r <= '0;
      look_r <= '0; off_r <= '0; rem_r <= '0; rec_r <= '0; oc_r <= OC_OK;
      fin_r <= 1'b0; skok_r <= 1'b0; fill_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; cont_r <= cont_nxt; sig_r <= sig_nxt; hdr_r <= hdr_nxt;
      chk_r <= chk_nxt; look_r <= look_nxt; off_r <= off_nxt; rem_r <= rem_nxt;
      rec_r <= rec_nxt; oc_r <= oc_nxt; fin_r <= fin_nxt; skok_r <= skok_nxt;
      fill_r <= fill_nxt;
    end
  end

  // offset of the current byte, wrapping at the offset width
  logic [OFFSET_BITS-1:0] off_inc;
  assign off_inc = off_r + 1'b1;

  // file-length headroom with the offset extended to 65 bits
  logic [64:0] off_w, flen_w;
  assign off_w = 65'(off_inc);
  assign flen_w = 65'(file_length);
  function automatic logic space_for(input logic [64:0] off, input logic [64:0] fl,
                                     input logic [33:0] len);
    space_for = (off <= fl) && (65'(len) <= fl - off);
  endfunction

  logic [32:0] lim;
  assign lim = (33'(meta_lim) < LEN_MAX) ? 33'(meta_lim) : LEN_MAX;

  // parser next state and burst build
  always_comb begin
    logic [15:0] rcnt;
    logic [33:0] len;
    logic [3:0] n;
    logic tp, hdr_match, done_rec;
    phase_nxt = phase_r; cont_nxt = cont_r; sig_nxt = sig_r; hdr_nxt = hdr_r;
    chk_nxt = chk_r; look_nxt = look_r; rem_nxt = rem_r; rec_nxt = rec_r;
    oc_nxt = oc_r; fin_nxt = fin_r; skok_nxt = skok_r; fill_nxt = fill_r;
    off_nxt = off_inc;
    burst = '0;
    n = '0;
    rcnt = rec_r + 16'd1;
    len = '0;
    tp = 1'b0; hdr_match = 1'b0; done_rec = 1'b0;
    case (phase_r)
      PH_SIG: begin
        if (fill_r < 4'd12) begin
          sig_nxt[fill_r] = b;
          fill_nxt = fill_r + 4'd1;
        end
        tp = (sig_nxt[0] == 8'h49 && sig_nxt[1] == 8'h49 && sig_nxt[2] == 8'h2A &&
              sig_nxt[3] == 8'h00) || (sig_nxt[0] == 8'h4D && sig_nxt[1] == 8'h4D &&
              sig_nxt[2] == 8'h00 && sig_nxt[3] == 8'h2A);
        if (fill_nxt == 4'd2 && sig_nxt[0] == 8'hFF && sig_nxt[1] == 8'hD8) begin
          cont_nxt = C_JPEG; rec_nxt = '0;
          phase_nxt = (rec_lim == 16'd0) ? PH_DONE : PH_JM0; fill_nxt = '0;
        end else if (fill_nxt == 4'd8) begin
          if (sig_nxt[7:0] == {8'h0A, 8'h1A, 8'h0A, 8'h0D, 8'h47, 8'h4E, 8'h50, 8'h89})
          begin
            cont_nxt = C_PNG; rec_nxt = '0;
            phase_nxt = (rec_lim == 16'd0) ? PH_DONE : PH_HDR; fill_nxt = '0;
          end else if (sig_nxt[3:0] == {8'h46, 8'h46, 8'h49, 8'h52}) begin
            phase_nxt = PH_SIG;
          end else if (tp) begin
            done_rec = 1'b1; // tiff start
          end else begin
            phase_nxt = PH_DONE;
          end
        end else if (fill_nxt == 4'd12) begin
          if (sig_nxt[11:8] == {8'h50, 8'h42, 8'h45, 8'h57}) begin
            cont_nxt = C_WEBP; rec_nxt = '0;
            phase_nxt = (rec_lim == 16'd0) ? PH_DONE : PH_HDR; fill_nxt = '0;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        if (eof && phase_nxt == PH_SIG && fill_nxt >= 4'd4 && fill_nxt < 4'd8 && tp)
          done_rec = 1'b1;
        if (done_rec) begin
          if (40'(file_length) > tiff_lim) begin
            oc_nxt = OC_LIMIT; phase_nxt = PH_DONE;
          end else begin
            for (int i = 0; i < 6; i++) burst.bytes[i] = exif_hdr_byte(3'(i));
            for (int i = 0; i < 8; i++)
              if (4'(i) < fill_nxt) burst.bytes[6+i] = sig_nxt[i];
            n = 4'd6 + fill_nxt;
            phase_nxt = PH_TIFF;
          end
        end
      end
      PH_JM0: phase_nxt = (b == 8'hFF) ? PH_JM1 : PH_DONE;
      PH_JM1: begin
        if (b == 8'hFF || (b >= 8'hD0 && b <= 8'hD7) || b == 8'h01) begin
          rec_nxt = rcnt;
          if (rcnt >= rec_lim) phase_nxt = PH_DONE;
          else if (b == 8'hFF) phase_nxt = PH_JM1;
          else begin phase_nxt = PH_JM0; fill_nxt = '0; end
        end else if (b == 8'hD9 || b == 8'hDA) begin
          phase_nxt = PH_DONE;
        end else begin
          hdr_nxt[0] = b; fill_nxt = '0; phase_nxt = PH_JLEN;
        end
      end
      PH_JLEN: begin
        hdr_nxt[1 + 32'(fill_r[0])] = b;
        fill_nxt = fill_r + 4'd1;
        if (fill_nxt >= 4'd2) begin
          len = {18'd0, hdr_nxt[1], hdr_nxt[2]};
          if (len < 34'd2) phase_nxt = PH_DONE;
          else begin
            len = len - 34'd2;
            if (hdr_nxt[0] == 8'hE1 && len >= 34'd6) begin
              skok_nxt = space_for(off_w, flen_w, len);
              rem_nxt = 33'(len); fill_nxt = '0; phase_nxt = PH_JPEEK;
            end else done_rec = 1'b1;
          end
        end
      end
      PH_JPEEK: begin
        if (fill_r < 4'd6) begin
          look_nxt[fill_r] = b; fill_nxt = fill_r + 4'd1;
        end
        if (fill_nxt >= 4'd6) begin
          if (look_nxt == {8'h00, 8'h00, 8'h66, 8'h69, 8'h78, 8'h45}) begin
            if (rem_r > lim) begin oc_nxt = OC_LIMIT; phase_nxt = PH_DONE; end
            else begin
              for (int i = 0; i < 6; i++) burst.bytes[i] = look_nxt[i];
              n = 4'd6;
              rem_nxt = rem_r - 33'd6;
              if (rem_nxt == '0) begin fin_nxt = 1'b1; phase_nxt = PH_DONE; end
              else phase_nxt = PH_BLOCK;
            end
          end else if (!skok_r) phase_nxt = PH_DONE;
          else begin
            rem_nxt = rem_r - 33'd6;
            if (rem_nxt == '0) begin
              rec_nxt = rcnt;
              phase_nxt = (rcnt >= rec_lim) ? PH_DONE : PH_JM0;
              fill_nxt = '0;
            end else phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        rem_nxt = rem_r - 33'd1;
        if (rem_nxt == '0) begin
          rec_nxt = rcnt; fill_nxt = '0;
          if (rcnt >= rec_lim) phase_nxt = PH_DONE;
          else phase_nxt = (cont_r == C_JPEG) ? PH_JM0 : PH_HDR;
        end
      end
      PH_HDR: begin
        chk_nxt[fill_r[2:0]] = b;
        fill_nxt = fill_r + 4'd1;
        if (fill_nxt >= 4'd8) begin
          if (cont_r == C_PNG) begin
            len = {2'd0, chk_nxt[0], chk_nxt[1], chk_nxt[2], chk_nxt[3]};
            if (chk_nxt[7:4] == {8'h44, 8'h4E, 8'h45, 8'h49}) phase_nxt = PH_DONE;
            else if (chk_nxt[7:4] == {8'h66, 8'h49, 8'h58, 8'h65}) begin
              if (len == '0) begin oc_nxt = OC_DAMAGED; phase_nxt = PH_DONE; end
              else if (33'(len) > lim) begin oc_nxt = OC_LIMIT; phase_nxt = PH_DONE; end
              else begin
                for (int i = 0; i < 6; i++) burst.bytes[i] = exif_hdr_byte(3'(i));
                n = 4'd6; rem_nxt = 33'(len); phase_nxt = PH_BLOCK;
              end
            end else begin
              len = len + 34'd4; done_rec = 1'b1;
            end
          end else begin
            len = {2'd0, chk_nxt[7], chk_nxt[6], chk_nxt[5], chk_nxt[4]};
            if (chk_nxt[3:0] == {8'h46, 8'h49, 8'h58, 8'h45}) begin
              if (len == '0) begin oc_nxt = OC_DAMAGED; phase_nxt = PH_DONE; end
              else if (33'(len) > lim) begin oc_nxt = OC_LIMIT; phase_nxt = PH_DONE; end
              else begin rem_nxt = 33'(len); fill_nxt = '0; phase_nxt = PH_WPEEK; end
            end else begin
              len = len + 34'(len[0]); done_rec = 1'b1;
            end
          end
        end
      end
      PH_WPEEK: begin
        if (fill_r < 4'd6) begin
          look_nxt[fill_r] = b; fill_nxt = fill_r + 4'd1;
        end
        rem_nxt = rem_r - 33'd1;
        if (fill_nxt >= 4'd6 || rem_nxt == '0) begin
          hdr_match = (fill_nxt >= 4'd6) &&
                      (look_nxt == {8'h00, 8'h00, 8'h66, 8'h69, 8'h78, 8'h45});
          if (!hdr_match) begin
            for (int i = 0; i < 6; i++) burst.bytes[i] = exif_hdr_byte(3'(i));
            for (int i = 0; i < 6; i++)
              if (4'(i) < fill_nxt) burst.bytes[6+i] = look_nxt[i];
            n = 4'd6 + fill_nxt;
          end else begin
            for (int i = 0; i < 6; i++) burst.bytes[i] = look_nxt[i];
            n = 4'd6;
          end
          if (rem_nxt == '0) begin fin_nxt = 1'b1; phase_nxt = PH_DONE; end
          else phase_nxt = PH_BLOCK;
        end
      end
      PH_BLOCK: begin
        burst.bytes[0] = b; n = 4'd1;
        rem_nxt = rem_r - 33'd1;
        if (rem_nxt == '0) begin fin_nxt = 1'b1; phase_nxt = PH_DONE; end
      end
      PH_TIFF: begin
        burst.bytes[0] = b; n = 4'd1;
      end
      default: ;
    endcase
    // start a skip for jpeg or chunk records
    if (done_rec && phase_r != PH_SIG) begin
      if (!space_for(off_w, flen_w, len)) phase_nxt = PH_DONE;
      else if (len == '0) begin
        rec_nxt = rcnt; fill_nxt = '0;
        if (rcnt >= rec_lim) phase_nxt = PH_DONE;
        else phase_nxt = (cont_r == C_JPEG) ? PH_JM0 : PH_HDR;
      end else begin
        rem_nxt = 33'(len); phase_nxt = PH_SKIP;
      end
    end
    burst.cnt = n;
    burst.fin = eof;
    burst.oc = oc_nxt;
    burst.kept = fin_nxt || (phase_nxt == PH_TIFF);
    // closing result returns the parser to its file start state
    if (eof) begin
      phase_nxt = PH_SIG; cont_nxt = C_JPEG; sig_nxt = '0; hdr_nxt = '0; chk_nxt = '0;
      look_nxt = '0; off_nxt = '0; rem_nxt = '0; rec_nxt = '0; oc_nxt = OC_OK;
      fin_nxt = 1'b0; skok_nxt = 1'b0; fill_nxt = '0;
    end
  end

endmodule
`default_nettype wire

// File: sv/exif_back.sv
// back: result queue drained one result per transfer
// depends on exif_pkg
`default_nettype none
module exif_back import exif_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  burst_t      burst,
  output logic        room,
  output logic        empty,
  output res_t        head,
  input  wire logic   pop
);

  localparam int DEPTH = 32;
  localparam int AW = $clog2(DEPTH);

  res_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic [4:0] total;

  assign total = 5'(burst.cnt) + 5'(burst.fin);
  // accept a burst only when the worst case fits
  assign room = cnt_r <= (AW+1)'(DEPTH - 16);
  assign empty = (cnt_r == '0);
  assign head = mem_r[rp_r];

  // queue storage, written one slot per burst entry
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        if (5'(i) < 5'(burst.cnt))
          mem_r[wp_r + AW'(i)] <= '{data: burst.bytes[i], vld: 1'b1, fin: 1'b0,
                                    oc: OC_OK, kept: 1'b0};
        else if (5'(i) == 5'(burst.cnt) && burst.fin)
          mem_r[wp_r + AW'(i)] <= '{data: 8'd0, vld: 1'b0, fin: 1'b1,
                                    oc: burst.oc, kept: burst.kept};
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(total);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (push ? (AW+1)'(total) : '0) - (pop ? (AW+1)'(1) : '0);
    end
  end

endmodule
`default_nettype wire

// File: sv/exif_block_locator_core.sv
// top level of the exif block locator: config registers, front parser, result queue
// depends on exif_pkg, exif_stream_if, exif_front, exif_back and the macros header
//
// in_ch carries one file byte per transfer with end_of_file on the last byte.
// out_ch carries results: a block byte (byte_valid 1) or the closing result
// (final_res 1, with outcome and payload_kept) after each file's last byte.
// Throughput: one input byte per cycle while the result queue has room for a
// worst-case burst of 15 results; a byte yields its results one per cycle.
// A byte's results are written into the result queue on its transfer and leave in order.
// A byte that opens the header or a TIFF prefix may emit up to 15 results; the
// queue absorbs them and in_ch ready drops until the queue drains enough.
// When out_ch is stalled results wait in the queue; nothing is lost.
// Reset (rst_n low, synchronous) clears the parser, empties the queue and
// loads the register defaults. Registers are written on cfg_we by index.
`default_nettype none
`include "exif_block_locator_core_macros.svh"
module exif_block_locator_core import exif_pkg::*; #(
  parameter int OFFSET_BITS = 40,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  exif_stream_if.sink                in_ch,
  exif_stream_if.source              out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [39:0] flen_r;
  logic [31:0] meta_r;
  logic [15:0] rec_r;
  logic [39:0] tiff_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r <= '0; meta_r <= 32'd1048576; rec_r <= 16'd1024; tiff_r <= 40'd16777216;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILE_LEN: flen_r <= cfg_data;
        CFG_META_LIM: meta_r <= cfg_data[31:0];
        CFG_REC_LIM:  rec_r <= cfg_data[15:0];
        CFG_TIFF_LIM: tiff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  burst_t burst;
  logic room, empty, step;
  res_t head;

  assign in_ch.ready = room;
  assign step = in_ch.valid && room;

  exif_front #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst_n, .step, .b(in_ch.payload[7:0]), .eof(in_ch.payload[8]),
    .file_length(flen_r), .meta_lim(meta_r), .rec_lim(rec_r), .tiff_lim(tiff_r),
    .burst
  );

  exif_back u_back (
    .clk, .rst_n, .push(step), .burst, .room, .empty, .head,
    .pop(out_ch.valid && out_ch.ready)
  );

  // result channel
  assign out_ch.valid = !empty;
  assign out_ch.payload = {head.data, head.vld, head.fin, head.oc, head.kept};

  // a result is either a block byte or a closing result
  `EBL_ASSERT(a_kind, out_ch.valid, head.vld != head.fin, "bad result kind")
  // no transfer into a full queue
  `EBL_ASSERT(a_room, in_ch.valid && in_ch.ready, room, "push without room")
  // reset leaves the queue empty
  `EBL_ASSERT_NEXT(a_rst, 1'b1, $past(rst_n) || empty, "queue not empty after reset")

endmodule
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for exif_block_locator_core
// depends on exif_pkg, exif_stream_if and the rtl core; byte-level predictor inside
`default_nettype none
module tb;
  import exif_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] EXIF_HDR = 48'h4578_6966_0000;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  exif_stream_if #(.T(logic [8:0])) in_if (clk);
  exif_stream_if #(.T(res_t)) out_if (clk);

  exif_block_locator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // register shadow
  logic [39:0] file_len_r;
  logic [31:0] meta_lim_r;
  logic [15:0] rec_lim_r;
  logic [39:0] tiff_lim_r;

  // parser shadow
  phase_t      ph;
  cont_t       cont;
  logic [7:0]  sig [12];
  logic [7:0]  hdr [8];
  logic [7:0]  look [6];
  logic [39:0] offs;
  longint unsigned remain;
  logic [15:0] recs;
  logic [1:0]  oc_held;
  bit          done_blk, skip_ok;
  int          fill;

  res_t exp_res_q [$];
  res_t burst_q [$];
  logic [7:0] file_q [$];

  int errors = 0, n_checked = 0, n_bytes = 0, n_files = 0, idle_cnt = 0;
  bit no_idle = 0, hold_req = 0;

  // directed table: byte, last, typed, outcome, kept
  typedef struct {
    logic [7:0] b; bit eof; bit typed; logic [1:0] oc; bit kept;
  } dir_row_t;
  dir_row_t dir_tab [26] = '{
    '{8'h00, 1, 1, OC_OK, 0},
    '{8'hFF, 1, 1, OC_OK, 0},
    '{8'hFF, 0, 0, OC_OK, 0}, '{8'hD8, 0, 0, OC_OK, 0},
    '{8'hFF, 0, 0, OC_OK, 0}, '{8'hD9, 1, 1, OC_OK, 0},
    '{8'h4D, 0, 0, OC_OK, 0}, '{8'h4D, 0, 0, OC_OK, 0},
    '{8'h00, 0, 0, OC_OK, 0}, '{8'h2A, 1, 0, OC_OK, 0},
    '{8'h89, 0, 0, OC_OK, 0}, '{8'h50, 0, 0, OC_OK, 0},
    '{8'h4E, 0, 0, OC_OK, 0}, '{8'h47, 0, 0, OC_OK, 0},
    '{8'h0D, 0, 0, OC_OK, 0}, '{8'h0A, 0, 0, OC_OK, 0},
    '{8'h1A, 0, 0, OC_OK, 0}, '{8'h0A, 0, 0, OC_OK, 0},
    '{8'h00, 0, 0, OC_OK, 0}, '{8'h00, 0, 0, OC_OK, 0},
    '{8'h00, 0, 0, OC_OK, 0}, '{8'h00, 0, 0, OC_OK, 0},
    '{8'h65, 0, 0, OC_OK, 0}, '{8'h58, 0, 0, OC_OK, 0},
    '{8'h49, 0, 0, OC_OK, 0}, '{8'h66, 1, 1, OC_DAMAGED, 0}
  };

  // ---------------- predictor ----------------
  function automatic void emit(logic [7:0] d, bit v, bit f, logic [1:0] o, bit k);
    res_t r;
    r.data = d; r.vld = v; r.fin = f; r.oc = o; r.kept = k;
    burst_q.push_back(r);
  endfunction

  function automatic void emit_exif_hdr();
    for (int i = 0; i < 6; i++) emit(EXIF_HDR[47-8*i -: 8], 1, 0, OC_OK, 0);
  endfunction

  function automatic void file_clear();
    ph = PH_SIG; cont = C_JPEG;
    foreach (sig[i]) sig[i] = '0;
    foreach (hdr[i]) hdr[i] = '0;
    foreach (look[i]) look[i] = '0;
    offs = '0; remain = 0; recs = '0; oc_held = OC_OK;
    done_blk = 0; skip_ok = 0; fill = 0;
  endfunction

  function automatic bit room_for(longint unsigned len);
    return (offs <= file_len_r) && (len <= longint'(file_len_r) - longint'(offs));
  endfunction

  function automatic void open_record();
    fill = 0;
    ph = (cont == C_JPEG) ? PH_JM0 : PH_HDR;
  endfunction

  function automatic void count_record();
    recs = recs + 16'd1;
    if (recs >= rec_lim_r) ph = PH_DONE;
    else open_record();
  endfunction

  function automatic void enter(cont_t c);
    cont = c; recs = '0;
    if (rec_lim_r == 0) ph = PH_DONE;
    else open_record();
  endfunction

  function automatic void begin_skip(longint unsigned len);
    if (!room_for(len)) ph = PH_DONE;
    else if (len == 0) count_record();
    else begin
      remain = len; ph = PH_SKIP;
    end
  endfunction

  function automatic bit size_ok(longint unsigned len);
    if (len == 0) begin
      oc_held = OC_DAMAGED; ph = PH_DONE; return 0;
    end
    if (len > meta_lim_r) begin
      oc_held = OC_LIMIT; ph = PH_DONE; return 0;
    end
    return 1;
  endfunction

  function automatic bit tiff_sig();
    logic [31:0] s;
    s = {sig[0], sig[1], sig[2], sig[3]};
    return s == 32'h4949_2A00 || s == 32'h4D4D_002A;
  endfunction

  function automatic void begin_tiff();
    if (file_len_r > tiff_lim_r) begin
      oc_held = OC_LIMIT; ph = PH_DONE;
    end else begin
      emit_exif_hdr();
      for (int i = 0; i < fill && i < 12; i++) emit(sig[i], 1, 0, OC_OK, 0);
      ph = PH_TIFF;
    end
  endfunction

  // expected results of one accepted byte, left in burst_q
  function automatic void predict_byte(logic [7:0] b, bit eof);
    longint unsigned len;
    burst_q.delete();
    offs = offs + 40'd1;
    case (ph)
      PH_SIG: begin
        if (fill < 12) begin
          sig[fill] = b; fill++;
        end
        if (fill == 2 && sig[0] == 8'hFF && sig[1] == 8'hD8) enter(C_JPEG);
        else if (fill == 8) begin
          if ({sig[0], sig[1], sig[2], sig[3], sig[4], sig[5], sig[6], sig[7]} ==
              64'h8950_4E47_0D0A_1A0A) enter(C_PNG);
          else if ({sig[0], sig[1], sig[2], sig[3]} == "RIFF") ;
          else if (tiff_sig()) begin_tiff();
          else ph = PH_DONE;
        end else if (fill == 12) begin
          if ({sig[8], sig[9], sig[10], sig[11]} == "WEBP") enter(C_WEBP);
          else ph = PH_DONE;
        end
        if (eof && ph == PH_SIG && fill >= 4 && fill < 8 && tiff_sig()) begin_tiff();
      end
      PH_JM0: ph = (b == 8'hFF) ? PH_JM1 : PH_DONE;
      PH_JM1: begin
        if (b == 8'hFF) begin
          count_record();
          if (ph != PH_DONE) ph = PH_JM1;
        end else if (b == 8'hD9 || b == 8'hDA) ph = PH_DONE;
        else if ((b >= 8'hD0 && b <= 8'hD7) || b == 8'h01) count_record();
        else begin
          hdr[0] = b; fill = 0; ph = PH_JLEN;
        end
      end
      PH_JLEN: begin
        hdr[1 + (fill & 1)] = b; fill++;
        if (fill >= 2) begin
          len = {hdr[1], hdr[2]};
          if (len < 2) ph = PH_DONE;
          else begin
            len -= 2;
            if (hdr[0] == 8'hE1 && len >= 6) begin
              skip_ok = room_for(len); remain = len; fill = 0; ph = PH_JPEEK;
            end else begin_skip(len);
          end
        end
      end
      PH_JPEEK: begin
        if (fill < 6) begin
          look[fill] = b; fill++;
        end
        if (fill >= 6) begin
          if ({look[0], look[1], look[2], look[3], look[4], look[5]} == EXIF_HDR) begin
            if (size_ok(remain)) begin
              for (int i = 0; i < 6; i++) emit(look[i], 1, 0, OC_OK, 0);
              remain -= 6;
              if (remain == 0) begin
                done_blk = 1; ph = PH_DONE;
              end else ph = PH_BLOCK;
            end
          end else if (!skip_ok) ph = PH_DONE;
          else begin
            remain -= 6;
            if (remain == 0) count_record();
            else ph = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        remain--;
        if (remain == 0) count_record();
      end
      PH_HDR: begin
        hdr[fill & 7] = b; fill++;
        if (fill >= 8) begin
          if (cont == C_PNG) begin
            len = {hdr[0], hdr[1], hdr[2], hdr[3]};
            if ({hdr[4], hdr[5], hdr[6], hdr[7]} == "IEND") ph = PH_DONE;
            else if ({hdr[4], hdr[5], hdr[6], hdr[7]} == "eXIf") begin
              if (size_ok(len)) begin
                emit_exif_hdr(); remain = len; ph = PH_BLOCK;
              end
            end else begin_skip(len + 4);
          end else begin
            len = {hdr[7], hdr[6], hdr[5], hdr[4]};
            if ({hdr[0], hdr[1], hdr[2], hdr[3]} == "EXIF") begin
              if (size_ok(len)) begin
                remain = len; fill = 0; ph = PH_WPEEK;
              end
            end else begin_skip(len + (len & 1));
          end
        end
      end
      PH_WPEEK: begin
        if (fill < 6) begin
          look[fill] = b; fill++;
        end
        remain--;
        if (fill >= 6 || remain == 0) begin
          if (!(fill >= 6 &&
                {look[0], look[1], look[2], look[3], look[4], look[5]} == EXIF_HDR))
            emit_exif_hdr();
          for (int i = 0; i < fill && i < 6; i++) emit(look[i], 1, 0, OC_OK, 0);
          if (remain == 0) begin
            done_blk = 1; ph = PH_DONE;
          end else ph = PH_BLOCK;
        end
      end
      PH_BLOCK: begin
        emit(b, 1, 0, OC_OK, 0);
        remain--;
        if (remain == 0) begin
          done_blk = 1; ph = PH_DONE;
        end
      end
      PH_TIFF: emit(b, 1, 0, OC_OK, 0);
      default: ;
    endcase
    if (eof) begin
      emit(8'h00, 0, 1, oc_held, done_blk || ph == PH_TIFF);
      file_clear();
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_FILE_LEN: file_len_r = val;
      CFG_META_LIM: meta_lim_r = val[31:0];
      CFG_REC_LIM:  rec_lim_r = val[15:0];
      default:      tiff_lim_r = val;
    endcase
  endtask

  // settle: nothing pending, then a margin
  task automatic wait_drained();
    in_if.valid = 0;
    while (exp_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one byte and predict on its transfer; valid stays high afterwards
  task automatic send_byte(logic [7:0] b, bit eof, bit typed, logic [1:0] oc, bit kept);
    int gap;
    res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_if.payload = {eof, b};
    in_if.valid = 1;
    do @(posedge clk); while (!in_if.ready);
    predict_byte(b, eof);
    if (typed) begin
      r.data = 8'h00; r.vld = 0; r.fin = 1; r.oc = oc; r.kept = kept;
      exp_res_q.push_back(r);
    end else
      foreach (burst_q[i]) exp_res_q.push_back(burst_q[i]);
    n_bytes++;
    if (eof) n_files++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, 0, OC_OK, 0);
    in_if.valid = 0;
  endtask

  // ---------------- file builders ----------------
  function automatic void put_rand(int n);
    repeat (n) file_q.push_back($urandom_range(0, 255));
  endfunction

  function automatic void put32(logic [31:0] w, bit le);
    for (int i = 0; i < 4; i++) file_q.push_back(le ? w[8*i +: 8] : w[31-8*i -: 8]);
  endfunction

  function automatic void put_exif_hdr();
    for (int i = 0; i < 6; i++) file_q.push_back(EXIF_HDR[47-8*i -: 8]);
  endfunction

  function automatic void build_jpeg();
    int n, len;
    logic [7:0] mk;
    file_q.push_back(8'hFF); file_q.push_back(8'hD8);
    repeat ($urandom_range(0, 3)) begin
      file_q.push_back(8'hFF);
      repeat ($urandom_range(0, 2)) file_q.push_back(8'hFF);
      case ($urandom_range(0, 4))
        0: file_q.push_back(8'hD0 + $urandom_range(0, 7));
        1: file_q.push_back(8'h01);
        default: begin
          mk = $urandom_range(8'hC0, 8'hFE);
          if (mk == 8'hE1 || mk == 8'hD9 || mk == 8'hDA || (mk >= 8'hD0 && mk <= 8'hD8))
            mk = 8'hE0;
          len = $urandom_range(2, 10);
          file_q.push_back(mk); file_q.push_back(0); file_q.push_back(len);
          put_rand(len - 2);
        end
      endcase
    end
    // app1 segment, usually carrying the exif header
    n = $urandom_range(0, 16);
    len = 8 + n;
    file_q.push_back(8'hFF); file_q.push_back(8'hE1);
    file_q.push_back(len >> 8); file_q.push_back(len[7:0]);
    if ($urandom_range(0, 4) != 0) put_exif_hdr();
    else put_rand(6);
    put_rand(n);
    file_q.push_back(8'hFF); file_q.push_back(8'hDA);
    put_rand($urandom_range(0, 4));
  endfunction

  function automatic void build_png();
    int n;
    put32(32'h8950_4E47, 0); put32(32'h0D0A_1A0A, 0);
    put32(4, 0); put32("IHDR", 0); put_rand(4); put_rand(4);
    n = $urandom_range(0, 18);
    put32(n, 0); put32("eXIf", 0); put_rand(n); put_rand(4);
    put32(0, 0); put32("IEND", 0); put_rand(4);
  endfunction

  function automatic void build_webp();
    int n, vlen;
    put32("RIFF", 0); put_rand(4); put32("WEBP", 0);
    vlen = $urandom_range(1, 7);
    put32("VP8 ", 0); put32(vlen, 1); put_rand(vlen + (vlen & 1));
    n = $urandom_range(0, 18);
    put32("EXIF", 0);
    if (n >= 6 && $urandom_range(0, 1)) begin
      put32(n, 1); put_exif_hdr(); put_rand(n - 6);
    end else begin
      put32(n, 1); put_rand(n);
    end
  endfunction

  function automatic void build_tiff();
    if ($urandom_range(0, 1)) put32(32'h4949_2A00, 0);
    else put32(32'h4D4D_002A, 0);
    put_rand($urandom_range(0, 16));
  endfunction

  // a random file, mostly well formed, sometimes damaged or pure noise
  function automatic void build_file();
    int k, cut;
    file_q.delete();
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: build_jpeg();
      3, 4: build_png();
      5, 6: build_webp();
      7, 8: build_tiff();
      default: put_rand($urandom_range(1, 12));
    endcase
    if ($urandom_range(0, 5) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = $urandom_range(0, 255);
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick(logic [CFG_DATA_W-1:0] a,
      logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // ---------------- receiver ----------------
  initial begin
    int gap;
    out_if.ready = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_if.ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready = 1;
      do @(posedge clk); while (!out_if.valid && !hold_req);
      @(negedge clk);
    end
  end

  // ---------------- result check and watchdog ----------------
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (exp_res_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = exp_res_q.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: want byte %h vld %b fin %b oc %0d kept %b, ",
                        "got byte %h vld %b fin %b oc %0d kept %b"},
                       want.data, want.vld, want.fin, want.oc, want.kept,
                       got.data, got.vld, got.fin, got.oc, got.kept);
          end
        end
      end
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cnt);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int rnd_bytes;
    bit held;
    in_if.valid = 0;
    in_if.payload = '0;
    file_len_r = '0; meta_lim_r = 32'd1048576; rec_lim_r = 16'd1024;
    tiff_lim_r = 40'd16777216;
    file_clear();
    repeat (6) @(negedge clk);
    rst_n = 1;

    // directed table against reset register values
    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].eof, dir_tab[i].typed, dir_tab[i].oc,
                dir_tab[i].kept);
    in_if.valid = 0;
    wait_drained();

    // register extremes
    cfg_write(CFG_META_LIM, 32'hFFFF_FFFF);
    cfg_write(CFG_REC_LIM, 16'hFFFF);
    cfg_write(CFG_TIFF_LIM, MAX40);
    cfg_write(CFG_FILE_LEN, MAX40);

    rnd_bytes = 0;
    held = 0;
    while (rnd_bytes < RANDOM_BYTES) begin
      build_file();
      wait_drained();
      if (n_files % 4 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
        cfg_write(CFG_META_LIM, pick(0, $urandom_range(4, 12), 1048576, 32'hFFFF_FFFF));
        cfg_write(CFG_REC_LIM, pick(0, 1, $urandom_range(2, 5), 16'hFFFF));
        cfg_write(CFG_TIFF_LIM, pick(0, $urandom_range(4, 20), 16777216, MAX40));
      end
      cfg_write(CFG_FILE_LEN, pick(file_q.size(), file_q.size(),
                                   $urandom_range(0, file_q.size()), MAX40));
      // one long receiver stall while bytes keep coming
      if (!held && rnd_bytes > RANDOM_BYTES / 3) begin
        cfg_write(CFG_META_LIM, 32'hFFFF_FFFF);
        cfg_write(CFG_TIFF_LIM, MAX40);
        file_q.delete();
        put32(32'h4949_2A00, 0);
        put_rand(40);
        hold_req = 1;
        held = 1;
      end
      rnd_bytes += file_q.size();
      send_file();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d files in %0d bytes: jpeg, png, webp, tiff and noise", n_files,
             n_bytes);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0 && exp_res_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/exif_pkg.sv
sv/exif_stream_if.sv
sv/exif_front.sv
sv/exif_back.sv
sv/exif_block_locator_core.sv
dv/tb.sv
